/* sv/cpd_pkg.sv */
// cpd_pkg: shared types and constants of the code point deque
// command codes, value widths, code point limits and the cell control bundle
// no dependencies
package cpd_pkg;

  localparam int IN_W      = 32;
  localparam int VAL_W     = 21;
  localparam int FILL_W    = 7;
  localparam int DEPTH_DEF = 64;

  localparam logic [IN_W-1:0] CP_MAX  = 32'h0010_FFFF;
  localparam logic [IN_W-1:0] SURR_LO = 32'h0000_D800;
  localparam logic [IN_W-1:0] SURR_HI = 32'h0000_DFFF;

  typedef enum logic [1:0] {
    CMD_PUSH_HEAD = 2'd0,
    CMD_PUSH_TAIL = 2'd1,
    CMD_POP_HEAD  = 2'd2,
    CMD_POP_TAIL  = 2'd3
  } cmd_t;

  // broadcast to every cell; only operations that succeed are set
  typedef struct packed {
    logic             push_head;
    logic             push_tail;
    logic             pop_head;
    logic             pop_tail;
    logic [VAL_W-1:0] wr_value;
  } cell_ctrl_t;

endpackage

/* sv/cpd_cmd_if.sv */
// cpd_cmd_if: command channel of the code point deque
// valid/ready handshake carrying cmd and push_value; depends on cpd_pkg
interface cpd_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [cpd_pkg::IN_W-1:0]  push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

/* sv/cpd_res_if.sv */
// cpd_res_if: result channel of the code point deque
// valid/ready handshake carrying ok, pop_value and fill_count; depends on cpd_pkg
interface cpd_res_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [cpd_pkg::VAL_W-1:0]   pop_value;
  logic [cpd_pkg::FILL_W-1:0]  fill_count;

  modport source (output valid, output ok, output pop_value, output fill_count, input ready);
  modport sink   (input valid, input ok, input pop_value, input fill_count, output ready);
endinterface

/* sv/cpd_cell.sv */
// cpd_cell: one storage cell of the deque chain
// holds a head-ordered copy, a tail-ordered copy and an occupied flag; depends on cpd_pkg
module cpd_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  cpd_pkg::cell_ctrl_t       ctrl,
  input  logic [cpd_pkg::VAL_W-1:0] fwd_left,
  input  logic [cpd_pkg::VAL_W-1:0] fwd_right,
  input  logic [cpd_pkg::VAL_W-1:0] rev_left,
  input  logic [cpd_pkg::VAL_W-1:0] rev_right,
  input  logic                      occ_left,
  input  logic                      occ_right,
  output logic [cpd_pkg::VAL_W-1:0] fwd,
  output logic [cpd_pkg::VAL_W-1:0] rev,
  output logic                      occ
);
  import cpd_pkg::*;

  logic first_free;

  // first empty cell past the stored entries
  assign first_free = occ_left && !occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.push_head || ctrl.push_tail) begin
      occ <= occ || occ_left;
    end else if (ctrl.pop_head || ctrl.pop_tail) begin
      occ <= occ && occ_right;
    end
  end

  // fwd chain: head at cell 0
  always_ff @(posedge clk) begin
    if (ctrl.push_head) begin
      fwd <= fwd_left;
    end else if (ctrl.pop_head) begin
      fwd <= fwd_right;
    end else if (ctrl.push_tail && first_free) begin
      fwd <= ctrl.wr_value;
    end
  end

  // rev chain: tail at cell 0
  always_ff @(posedge clk) begin
    if (ctrl.push_tail) begin
      rev <= rev_left;
    end else if (ctrl.pop_tail) begin
      rev <= rev_right;
    end else if (ctrl.push_head && first_free) begin
      rev <= ctrl.wr_value;
    end
  end

endmodule

/* sv/code_point_deque_core.sv */
// code_point_deque_core: double-ended queue of unicode code points built as a chain of cells
// depends on cpd_pkg, cpd_cmd_if, cpd_res_if and cpd_cell
//
//   channel   dir   handshake      payload
//   cmd_ch    in    valid/ready    cmd[1:0], push_value[31:0]
//   res_ch    out   valid/ready    ok, pop_value[20:0], fill_count[6:0]
//
// one item per cycle while no result waits unread: the chain updates at the accept edge and the result
// lands in the output register on the same edge, so the next item can be taken in the following cycle
// reset clears the occupied flags, the fill counter and the result valid flag; cell data
// and the result payload are left as is and are only read once written
// cmd_ch.ready drops only while a finished result sits unread and res_ch.ready is low
module code_point_deque_core #(
  parameter int DEPTH = cpd_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cpd_cmd_if.sink     cmd_ch,
  cpd_res_if.source   res_ch
);
  import cpd_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // two copies of the contents: fwd keeps the head at cell 0, rev keeps the tail at
  // cell 0, so both ends are always read at a fixed place; occ is a thermometer
  // marking the stored entries, shared by both copies
  logic [VAL_W-1:0] fwd_q [DEPTH];
  logic [VAL_W-1:0] rev_q [DEPTH];
  logic [DEPTH-1:0] occ_q;

  cell_ctrl_t       ctrl;
  logic             accept;
  logic             valid_cp;
  logic             is_empty;
  logic             is_full;
  logic             op_ok;
  logic [VAL_W-1:0] op_value;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W+FILL_W-1:0] count_wide;
  cmd_t             cmd;

  // result register
  logic             res_valid;
  logic             res_ok;
  logic [VAL_W-1:0] res_pop_value;
  logic [FILL_W-1:0] res_fill;

  assign cmd_ch.ready = !res_valid || res_ch.ready;
  assign accept       = cmd_ch.valid && cmd_ch.ready;

  assign res_ch.valid      = res_valid;
  assign res_ch.ok         = res_ok;
  assign res_ch.pop_value  = res_pop_value;
  assign res_ch.fill_count = res_fill;

  assign cmd = cmd_t'(cmd_ch.cmd);

  // a code point is at most 0x10ffff and not a surrogate
  assign valid_cp = (cmd_ch.push_value <= CP_MAX) &&
                    !((cmd_ch.push_value >= SURR_LO) && (cmd_ch.push_value <= SURR_HI));

  // full and empty come straight from the ends of the thermometer
  assign is_empty = !occ_q[0];
  assign is_full  = occ_q[DEPTH-1];

  // decode: only successful operations reach the cells
  always_comb begin
    ctrl          = '0;
    ctrl.wr_value = cmd_ch.push_value[VAL_W-1:0];
    op_ok         = 1'b0;
    op_value      = '0;
    case (cmd)
      CMD_PUSH_HEAD: begin
        op_ok          = valid_cp && !is_full;
        ctrl.push_head = accept && op_ok;
      end
      CMD_PUSH_TAIL: begin
        op_ok          = valid_cp && !is_full;
        ctrl.push_tail = accept && op_ok;
      end
      CMD_POP_HEAD: begin
        op_ok         = !is_empty;
        ctrl.pop_head = accept && op_ok;
        op_value      = op_ok ? fwd_q[0] : '0;
      end
      CMD_POP_TAIL: begin
        op_ok         = !is_empty;
        ctrl.pop_tail = accept && op_ok;
        op_value      = op_ok ? rev_q[0] : '0;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  // fill counter follows the successful operations
  always_comb begin
    count_next = count;
    if (ctrl.push_head || ctrl.push_tail) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pop_head || ctrl.pop_tail) begin
      count_next = count - CNT_W'(1);
    end
  end

  // fill_count reports the count modulo 128
  assign count_wide = (CNT_W + FILL_W)'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_ok        <= op_ok;
      res_pop_value <= op_value;
      res_fill      <= count_wide[FILL_W-1:0];
    end
  end

  // the chain: each cell talks to its left and right neighbors only; cell 0 takes the
  // pushed value from the left, the last cell sees an empty neighbor on the right
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] fwd_l, fwd_r, rev_l, rev_r;
    logic             occ_l, occ_r;

    if (i == 0) begin : g_first
      assign fwd_l = ctrl.wr_value;
      assign rev_l = ctrl.wr_value;
      assign occ_l = 1'b1;
    end else begin : g_mid_l
      assign fwd_l = fwd_q[i-1];
      assign rev_l = rev_q[i-1];
      assign occ_l = occ_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign fwd_r = '0;
      assign rev_r = '0;
      assign occ_r = 1'b0;
    end else begin : g_mid_r
      assign fwd_r = fwd_q[i+1];
      assign rev_r = rev_q[i+1];
      assign occ_r = occ_q[i+1];
    end

    cpd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .fwd_left  (fwd_l),
      .fwd_right (fwd_r),
      .rev_left  (rev_l),
      .rev_right (rev_r),
      .occ_left  (occ_l),
      .occ_right (occ_r),
      .fwd       (fwd_q[i]),
      .rev       (rev_q[i]),
      .occ       (occ_q[i])
    );
  end

endmodule
